// ===== rtl/ntpd_pkg.sv =====
package ntpd_pkg;

    // Widths of the datapath
    localparam int MAGW  = 33;          // magnitude of a 33-bit signed difference
    localparam int PRODW = 2 * MAGW;    // one multiplier product
    localparam int WIDEW = 98;          // numerator terms and denominator
    localparam int NUMW  = WIDEW + 16;  // numerator scaled by 2^16
    localparam int QW    = 34;          // quotient bits, bits beyond the 32-bit slope range flag overflow
    localparam int DSHW  = WIDEW + QW - 1;
    localparam int LVLW  = 7;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] sample_value;
        logic               column_start;
    } point_t;

    typedef struct packed {
        logic signed [31:0] slope;
        logic [LVLW-1:0]    level_index;
        logic               degenerate;
        logic               saturated;
    } result_t;

    // One classified window, handed from front to back
    typedef struct packed {
        logic [MAGW-1:0] m0;
        logic [MAGW-1:0] m1;
        logic [MAGW-1:0] ms;
        logic [MAGW-1:0] mya;
        logic [MAGW-1:0] myb;
        logic            na;
        logic            nb;
        logic            dneg;
        logic            degen;
        logic [LVLW-1:0] level_index;
    } job_t;

    function automatic logic [MAGW-1:0] mag33(input logic [MAGW-1:0] v);
        return v[MAGW-1] ? (~v + MAGW'(1)) : v;
    endfunction

endpackage

// ===== rtl/ntpd_front.sv =====
module ntpd_front
    import ntpd_pkg::*;
#(
    parameter int LEVELS = 128
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  point_t point,
    input  logic   q_full,
    output logic   full,
    output logic   job_push,
    output job_t   job
);

    localparam int IDXW = $clog2(LEVELS + 1);

    logic signed [31:0] older_pos_reg, older_val_reg, mid_pos_reg, mid_val_reg;
    logic [IDXW-1:0]    seen_reg;

    logic            accept;
    logic            in_range;
    logic [IDXW-1:0] idx;
    logic [MAGW-1:0] h0, h1, hs, dya, dyb;

    assign full   = q_full;
    assign accept = push & ~q_full;

    // Classify the incoming point
    assign idx      = point.column_start ? '0 : seen_reg;
    assign in_range = idx < IDXW'(LEVELS);
    assign job_push = accept & in_range & (idx >= IDXW'(2));

    // Window differences, one bit wider than the inputs
    assign h0  = {mid_pos_reg[31], mid_pos_reg} - {older_pos_reg[31], older_pos_reg};
    assign h1  = {point.position[31], point.position} - {mid_pos_reg[31], mid_pos_reg};
    assign hs  = {point.position[31], point.position} - {older_pos_reg[31], older_pos_reg};
    assign dya = {mid_val_reg[31], mid_val_reg} - {older_val_reg[31], older_val_reg};
    assign dyb = {point.sample_value[31], point.sample_value}
               - {mid_val_reg[31], mid_val_reg};

    always_comb
    begin
        job.m0          = mag33(h0);
        job.m1          = mag33(h1);
        job.ms          = mag33(hs);
        job.mya         = mag33(dya);
        job.myb         = mag33(dyb);
        job.na          = dya[MAGW-1];
        job.nb          = dyb[MAGW-1];
        job.dneg        = h0[MAGW-1] ^ h1[MAGW-1] ^ hs[MAGW-1];
        job.degen       = (h0 == '0) || (h1 == '0) || (hs == '0);
        job.level_index = LVLW'(idx - IDXW'(1));
    end

    // Advance the window on every point within the column limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_pos_reg <= '0;
            older_val_reg <= '0;
            mid_pos_reg   <= '0;
            mid_val_reg   <= '0;
            seen_reg      <= '0;
        end
        else if (accept && in_range)
        begin
            if (point.column_start)
            begin
                older_pos_reg <= '0;
                older_val_reg <= '0;
            end
            else
            begin
                older_pos_reg <= mid_pos_reg;
                older_val_reg <= mid_val_reg;
            end
            mid_pos_reg <= point.position;
            mid_val_reg <= point.sample_value;
            seen_reg    <= idx + IDXW'(1);
        end
    end

endmodule

// ===== rtl/ntpd_queue.sv =====
module ntpd_queue
    import ntpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  job_t wr_job,
    input  logic rd,
    output job_t rd_job,
    output logic empty,
    output logic full
);

    localparam int PW = $clog2(QDEPTH);

    job_t              slot_reg [QDEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]       count_reg;
    logic              do_wr, do_rd;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == (PW + 1)'(QDEPTH));
    assign do_wr  = wr & ~full;
    assign do_rd  = rd & ~empty;
    assign rd_job = slot_reg[rd_ptr_reg];

    // Hold queued jobs
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (PW + 1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - (PW + 1)'(1);
            end
        end
    end

endmodule

// ===== rtl/ntpd_back.sv =====
module ntpd_back
    import ntpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    input  job_t    job,
    output logic    job_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    localparam logic [5:0] MUL_LAST = 6'd9;
    localparam logic [5:0] DIV_LAST = 6'(QW - 1);

    state_t            state_reg, state_next;
    logic [5:0]        cnt_reg;
    job_t              job_reg;
    logic [PRODW-1:0]  prod_reg;
    logic [WIDEW-1:0]  ta_reg, tb_reg, den_reg;
    logic [NUMW-1:0]   rem_reg;
    logic [DSHW-1:0]   dsh_reg;
    logic [QW-1:0]     q_reg;
    logic              neg_reg;
    result_t           out_reg;
    logic              out_valid_reg;

    logic [MAGW-1:0]   mul_a, mul_b;
    logic [PRODW-1:0]  mul_p;
    logic [WIDEW-1:0]  lo_term, hi_term;
    logic              same_sign, ta_ge;
    logic [WIDEW-1:0]  num;
    logic              nneg;
    logic              div_ge;
    logic [DSHW-1:0]   div_diff;
    result_t           res;
    logic              out_free;

    assign empty    = ~out_valid_reg;
    assign result   = out_reg;
    assign job_pop  = (state_reg == S_IDLE) & job_valid;
    assign out_free = ~out_valid_reg | pop;

    // Pick multiplier operands for each step
    always_comb
    begin
        unique case (cnt_reg)
            6'd0:    begin mul_a = job_reg.m1;                mul_b = job_reg.m1;  end
            6'd1:    begin mul_a = prod_reg[MAGW-1:0];        mul_b = job_reg.mya; end
            6'd2:    begin mul_a = prod_reg[PRODW-1:MAGW];    mul_b = job_reg.mya; end
            6'd3:    begin mul_a = job_reg.m0;                mul_b = job_reg.m0;  end
            6'd4:    begin mul_a = prod_reg[MAGW-1:0];        mul_b = job_reg.myb; end
            6'd5:    begin mul_a = prod_reg[PRODW-1:MAGW];    mul_b = job_reg.myb; end
            6'd6:    begin mul_a = job_reg.m0;                mul_b = job_reg.m1;  end
            6'd7:    begin mul_a = prod_reg[MAGW-1:0];        mul_b = job_reg.ms;  end
            6'd8:    begin mul_a = prod_reg[PRODW-1:MAGW];    mul_b = job_reg.ms;  end
            default: begin mul_a = '0;                        mul_b = '0;          end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign lo_term = WIDEW'(mul_p);
    assign hi_term = WIDEW'({mul_p, {MAGW{1'b0}}});

    // Combine the signed numerator terms
    assign same_sign = (job_reg.na == job_reg.nb);
    assign ta_ge     = (ta_reg >= tb_reg);
    always_comb
    begin
        priority if (same_sign)
        begin
            num  = ta_reg + tb_reg;
            nneg = job_reg.na;
        end
        else if (ta_ge)
        begin
            num  = ta_reg - tb_reg;
            nneg = job_reg.na;
        end
        else
        begin
            num  = tb_reg - ta_reg;
            nneg = job_reg.nb;
        end
    end

    // One restoring division step
    assign div_ge   = {{(DSHW - NUMW){1'b0}}, rem_reg} >= dsh_reg;
    assign div_diff = {{(DSHW - NUMW){1'b0}}, rem_reg} - dsh_reg;

    // Saturate and sign the quotient, or give zero for a degenerate window
    always_comb
    begin
        res.level_index = job_reg.level_index;
        res.degenerate  = job_reg.degen;
        if (job_reg.degen)
        begin
            res.slope     = '0;
            res.saturated = 1'b0;
        end
        else if (!neg_reg)
        begin
            res.saturated = |q_reg[QW-1:31];
            res.slope     = res.saturated ? 32'sh7FFF_FFFF : q_reg[31:0];
        end
        else
        begin
            res.saturated = (|q_reg[QW-1:32]) | (q_reg[31] & (|q_reg[30:0]));
            res.slope     = res.saturated ? 32'sh8000_0000 : (32'd0 - q_reg[31:0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (job_valid) state_next = job.degen ? S_OUT : S_MUL;
            S_MUL:   if (cnt_reg == MUL_LAST) state_next = S_DIV;
            S_DIV:   if (cnt_reg == DIV_LAST) state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequence multiply, divide and hand-off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:  cnt_reg <= '0;
                S_MUL:   cnt_reg <= (cnt_reg == MUL_LAST) ? '0 : cnt_reg + 6'd1;
                S_DIV:   cnt_reg <= cnt_reg + 6'd1;
                S_OUT:   cnt_reg <= '0;
                default: cnt_reg <= '0;
            endcase
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end
        if (state_reg == S_MUL)
        begin
            unique case (cnt_reg)
                6'd0, 6'd3, 6'd6: prod_reg <= mul_p;
                6'd1:    ta_reg  <= lo_term;
                6'd2:    ta_reg  <= ta_reg + hi_term;
                6'd4:    tb_reg  <= lo_term;
                6'd5:    tb_reg  <= tb_reg + hi_term;
                6'd7:    den_reg <= lo_term;
                6'd8:    den_reg <= den_reg + hi_term;
                default:
                begin
                    rem_reg <= {num, 16'd0};
                    dsh_reg <= {den_reg, {(QW - 1){1'b0}}};
                    neg_reg <= nneg ^ job_reg.dneg;
                    q_reg   <= '0;
                end
            endcase
        end
        if (state_reg == S_DIV)
        begin
            if (div_ge)
            begin
                rem_reg <= NUMW'(div_diff);
            end
            q_reg   <= {q_reg[QW-2:0], div_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_reg <= res;
        end
    end

endmodule

// ===== rtl/nonuniform_three_point_derivative.sv =====
// Channel   Handshake            Payload
// point     push / full          point_t: position, sample_value, column_start
// result    pop / empty          result_t: slope, level_index, degenerate, saturated
//
// A point is taken while full is low; a window goes to the back end through a two-entry queue.
// A regular result takes an idle step, 10 multiply steps, 34 divide steps and a hand-off,
// set by the shared 33x33 multiplier and the one-bit-per-cycle divider.
// Coincident positions skip the arithmetic and go straight to the hand-off.
// Reset clears the window, the queue and the result slot; full stays high while
// the queue holds two windows, and the back end waits while a result is not popped.
module nonuniform_three_point_derivative
    import ntpd_pkg::*;
#(
    parameter int LEVELS = 128
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  point_t  point,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic q_full, q_empty, job_push, job_pop;
    job_t job_in, job_out;

    ntpd_front #(.LEVELS(LEVELS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .point    (point),
        .q_full   (q_full),
        .full     (full),
        .job_push (job_push),
        .job      (job_in)
    );

    ntpd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_push),
        .wr_job (job_in),
        .rd     (job_pop),
        .rd_job (job_out),
        .empty  (q_empty),
        .full   (q_full)
    );

    ntpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (~q_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

// ===== tb/sv/tb_nonuniform_three_point_derivative.sv =====
`timescale 1ns / 100ps

module tb_nonuniform_three_point_derivative;
    import ntpd_pkg::*;

    localparam int LEVELS     = 128;
    localparam int STALL_MAX  = 3000;
    localparam int DRAIN_WAIT = 200;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    push;
    logic    full;
    point_t  point;
    logic    empty;
    logic    pop;
    result_t result;

    nonuniform_three_point_derivative #(.LEVELS(LEVELS)) DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .point  (point),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Window state of the slope predictor
    logic signed [31:0] prev2_pos;
    logic signed [31:0] prev2_val;
    logic signed [31:0] prev1_pos;
    logic signed [31:0] prev1_val;
    int unsigned        col_count;

    result_t pending_slopes[$];
    int      mismatches = 0;
    int      idle_cycles;
    bit      quiet;

    // Stimulus table row: typed expectation only where obvious
    typedef struct {
        point_t  pt;
        bit      known;
        result_t want;
    } row_t;

    row_t directed[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance the window by one point and queue the slope it produces
    function automatic bit predict_slope(input point_t p);
        logic signed [159:0] h0;
        logic signed [159:0] h1;
        logic signed [159:0] hs;
        logic signed [159:0] dya;
        logic signed [159:0] dyb;
        logic signed [159:0] num;
        logic signed [159:0] den;
        logic signed [159:0] q;
        int unsigned         idx;
        result_t             r;
        bit                  made;
        idx  = p.column_start ? 0 : col_count;
        made = 1'b0;
        if (idx >= LEVELS)
            return 1'b0;
        if (idx >= 2)
        begin
            h0 = prev1_pos;
            h0 = h0 - prev2_pos;
            h1 = p.position;
            h1 = h1 - prev1_pos;
            hs = p.position;
            hs = hs - prev2_pos;
            r.level_index = LVLW'(idx - 1);
            r.degenerate  = 1'b0;
            r.saturated   = 1'b0;
            r.slope       = '0;
            if (h0 == 0 || h1 == 0 || hs == 0)
                r.degenerate = 1'b1;
            else
            begin
                dya = prev1_val;
                dya = dya - prev2_val;
                dyb = p.sample_value;
                dyb = dyb - prev1_val;
                num = (h1 * h1 * dya + h0 * h0 * dyb) * 65536;
                den = h0 * h1 * hs;
                q   = num / den;
                if (q > 160'sh7FFFFFFF)
                begin
                    r.slope     = 32'h7FFFFFFF;
                    r.saturated = 1'b1;
                end
                else if (q < -160'sh80000000)
                begin
                    r.slope     = 32'h80000000;
                    r.saturated = 1'b1;
                end
                else
                    r.slope = q[31:0];
            end
            pending_slopes.push_back(r);
            made = 1'b1;
        end
        if (p.column_start)
        begin
            prev2_pos = '0;
            prev2_val = '0;
        end
        else
        begin
            prev2_pos = prev1_pos;
            prev2_val = prev1_val;
        end
        prev1_pos = p.position;
        prev1_val = p.sample_value;
        col_count = idx + 1;
        return made;
    endfunction

    // Drive one point and hold it until the beat is taken
    task automatic put_point(input point_t p, output bit made);
        @(negedge clk);
        push  <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (full);
        made = predict_slope(p);
    endtask

    // Drop push for a random burst of cycles
    task automatic sender_gap();
        int n;
        if (quiet || $urandom_range(0, 5) != 0)
            return;
        n = $urandom_range(1, 12);
        @(negedge clk);
        push <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    function automatic point_t mk(input int x, input int y, input bit s);
        point_t p;
        p.position     = x;
        p.sample_value = y;
        p.column_start = s;
        return p;
    endfunction

    function automatic result_t res(input int s, input int i, input bit d, input bit sat);
        result_t r;
        r.slope       = s;
        r.level_index = LVLW'(i);
        r.degenerate  = d;
        r.saturated   = sat;
        return r;
    endfunction

    task automatic add_row(input point_t p, input bit k, input result_t w);
        row_t r;
        r.pt    = p;
        r.known = k;
        r.want  = w;
        directed.push_back(r);
    endtask

    // One random column: mostly well formed, some short or with repeats
    task automatic random_column(input int len);
        int        x;
        int        y;
        bit        wide;
        bit        made;
        point_t    p;
        wide = ($urandom_range(0, 3) == 0);
        x    = wide ? $urandom : $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        y    = $urandom;
        for (int k = 0; k < len; k++)
        begin
            p = mk(x, y, k == 0);
            // Occasional column-start flag dropped on a column head
            if (k == 0 && $urandom_range(0, 30) == 0)
                p.column_start = 1'b0;
            sender_gap();
            put_point(p, made);
            if (wide)
                x = $urandom;
            else if ($urandom_range(0, 15) != 0)
                x = x + $urandom_range(1, 32'h0004_0000);
            case ($urandom_range(0, 3))
                0: y = $urandom;
                1: y = y + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
                2: y = y ^ (1 << $urandom_range(0, 31));
                default: y = -y;
            endcase
        end
    endtask

    // Receiver: pop in random bursts, steady at the end
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet || $urandom_range(0, 4) != 0)
                pop <= 1'b1;
            else
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
        end
    end

    // Check each popped beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_slopes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", result);
            end
            else
            begin
                if (result !== pending_slopes[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", pending_slopes[0], result);
                end
                void'(pending_slopes.pop_front());
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        bit made;
        rst_n       = 1'b0;
        push        = 1'b0;
        point       = '0;
        quiet       = 1'b0;
        prev2_pos   = '0;
        prev2_val   = '0;
        prev1_pos   = '0;
        prev1_val   = '0;
        col_count   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: first point without a column flag after reset, linear ramp
        add_row(mk(0, 0, 0), 0, '0);
        add_row(mk(32'h10000, 32'h10000, 0), 0, '0);
        add_row(mk(32'h20000, 32'h20000, 0), 1, res(32'h10000, 1, 0, 0));
        add_row(mk(32'h40000, 32'h60000, 0), 0, '0);
        // Coincident positions
        add_row(mk(5, 7, 1), 0, '0);
        add_row(mk(5, 9, 0), 0, '0);
        add_row(mk(9, 1, 0), 1, res(0, 1, 1, 0));
        add_row(mk(-3, 2, 0), 0, '0);
        add_row(mk(9, 2, 0), 1, res(0, 3, 1, 0));
        // Clipping, both signs
        add_row(mk(0, 32'h80000000, 1), 0, '0);
        add_row(mk(1, 32'h7FFFFFFF, 0), 0, '0);
        add_row(mk(2, 32'h7FFFFFFF, 0), 1, res(32'h7FFFFFFF, 1, 0, 1));
        add_row(mk(0, 32'h7FFFFFFF, 1), 0, '0);
        add_row(mk(1, 32'h80000000, 0), 0, '0);
        add_row(mk(2, 32'h80000000, 0), 1, res(32'h80000000, 1, 0, 1));
        // Extreme positions
        add_row(mk(32'h80000000, 32'h7FFFFFFF, 1), 0, '0);
        add_row(mk(32'h7FFFFFFF, 32'h80000000, 0), 0, '0);
        add_row(mk(32'h80000000, 0, 0), 1, res(0, 1, 1, 0));
        add_row(mk(32'h80000000, 32'hFFFFFFFF, 1), 0, '0);
        add_row(mk(32'hFFFFFFFF, 0, 0), 0, '0);
        add_row(mk(32'h7FFFFFFF, 32'h12345678, 0), 0, '0);
        add_row(mk(32'h7FFFFFFE, 32'hEDCBA987, 0), 0, '0);
        foreach (directed[i])
        begin
            put_point(directed[i].pt, made);
            if (directed[i].known && made)
            begin
                void'(pending_slopes.pop_back());
                pending_slopes.push_back(directed[i].want);
            end
        end

        // Random columns; a few run past the level limit
        for (int c = 0; c < 120; c++)
        begin
            if (c == 40)
            begin
                // Hold the sender until every slope is out
                @(negedge clk);
                push <= 1'b0;
                wait (pending_slopes.size() == 0);
            end
            if (c == 100)
                quiet = 1'b1;
            if (c % 45 == 7)
                random_column($urandom_range(LEVELS + 1, LEVELS + 6));
            else if ($urandom_range(0, 9) == 0)
                random_column($urandom_range(1, 2));
            else
                random_column($urandom_range(3, 9));
        end
        @(negedge clk);
        push <= 1'b0;

        wait (pending_slopes.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_slopes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ntpd_pkg.sv
rtl/ntpd_front.sv
rtl/ntpd_queue.sv
rtl/ntpd_back.sv
rtl/nonuniform_three_point_derivative.sv
tb/sv/tb_nonuniform_three_point_derivative.sv
